// ===== rtl/wsr_pkg.sv =====
package wsr_pkg;

    localparam int HALF_TAPS      = 64;
    localparam int STEPS          = 32;
    localparam int LINE_LEN       = 136;
    localparam int TAB_LEN        = HALF_TAPS * STEPS;
    localparam int MAX_RESULTS    = 64;
    localparam int SAMPLE_W       = 16;
    localparam int ACC_W          = 42;
    localparam int ROM_W          = 18;
    localparam int ROM_AW         = 12;
    localparam int IDX_W          = 7;
    localparam int LINE_AW        = 8;
    localparam int DIST_W         = 22;
    localparam int MULK_W         = 17;
    localparam int RATIO_W        = 23;
    localparam int TIME_W         = 33;
    localparam int FT_W           = 17;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Configuration register indexes
    localparam logic REG_RATIO   = 1'b0;
    localparam logic REG_INVERSE = 1'b1;

    typedef logic signed [ROM_W-1:0] t_rom [0:TAB_LEN];

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_TAPS,
        ST_DRAIN,
        ST_STEP,
        ST_EMIT,
        ST_FINAL,
        ST_PUSHN
    } t_state;

    typedef struct packed {
        logic                push;
        logic [SAMPLE_W-1:0] wdata;
        logic [IDX_W-1:0]    rd_idx;
    } t_line_req;

    typedef struct packed {
        logic              clr;
        logic              tap_valid;
        logic [DIST_W-1:0] tap_dist;
    } t_mac_ctl;

    // Long division by shift and subtract, used for table generation only
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[63:0], num[k]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(pi*n/d) in Q30 by Taylor series
    function automatic logic signed [63:0] f_sin_pi(input logic [63:0] n, input logic [63:0] d);
        logic [63:0]        m;
        logic               neg;
        logic [63:0]        a;
        logic [63:0]        term;
        logic signed [63:0] sum;
        m = n - f_udiv(n, d << 1) * (d << 1);
        neg = (m >= d);
        if (neg) begin
            m = m - d;
        end
        if ((m << 1) > d) begin
            m = d - m;
        end
        a = f_udiv(PI_Q30 * m, d);
        term = a;
        sum = signed'(a);
        for (int k = 1; k <= 9; k++) begin
            term = (((term * a) >> 30) * a) >> 30;
            term = f_udiv(term, 64'((2 * k) * (2 * k + 1)));
            if ((k % 2) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return neg ? -sum : sum;
    endfunction

    // Hann-windowed sinc, signed Q2.16, STEPS entries per zero crossing
    function automatic t_rom f_build_rom();
        t_rom               rom;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic               neg;
        logic [63:0]        mag;
        logic [63:0]        den;
        logic [63:0]        sq;
        logic [63:0]        w;
        logic [63:0]        v;
        rom[0] = ROM_W'(65536);
        for (int i = 1; i < TAB_LEN; i++) begin
            s   = f_sin_pi(64'(i), 64'(STEPS));
            neg = s[63];
            mag = neg ? 64'(-s) : 64'(s);
            den = PI_Q30 * 64'(i);
            sq  = f_udiv(mag * 64'(STEPS) * 64'd65536 + (den >> 1), den);
            c   = f_sin_pi(64'(2 * i + TAB_LEN), 64'(2 * TAB_LEN));
            w   = 64'(64'sd1073741824 + c);
            v   = (sq * w + 64'd1073741824) >> 31;
            rom[i] = neg ? -ROM_W'(v) : ROM_W'(v);
        end
        rom[TAB_LEN] = '0;
        return rom;
    endfunction

    localparam t_rom SINC_ROM = f_build_rom();

endpackage

// ===== rtl/wsr_delay_ram.sv =====
module wsr_delay_ram import wsr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_line_req                  i_req,
    output logic                       o_ready,
    output logic signed [SAMPLE_W-1:0] o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [0:LINE_LEN-1];
    logic [LINE_AW-1:0]  r_head;
    logic [LINE_AW-1:0]  r_clr_addr;
    logic                r_clr_active;
    logic [LINE_AW:0]    rd_sum;
    logic [LINE_AW-1:0]  rd_addr;
    logic [SAMPLE_W-1:0] r_rd_data;

    // Map the logical tap index onto the circular buffer
    always_comb begin
        rd_sum = {1'b0, r_head} + (LINE_AW + 1)'(i_req.rd_idx);
        if (rd_sum >= (LINE_AW + 1)'(LINE_LEN)) begin
            rd_sum = rd_sum - (LINE_AW + 1)'(LINE_LEN);
        end
        rd_addr = rd_sum[LINE_AW-1:0];
    end

    // Sweep zeros after reset, then advance the head on each push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_clr_addr   <= '0;
            r_clr_active <= 1'b1;
        end else if (r_clr_active) begin
            if (r_clr_addr == LINE_AW'(LINE_LEN - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end else if (i_req.push) begin
            r_head <= (r_head == LINE_AW'(LINE_LEN - 1)) ? '0 : r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.push) begin
            r_mem[r_head] <= i_req.wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_ready   = !r_clr_active;
    assign o_rd_data = signed'(r_rd_data);

endmodule

// ===== rtl/wsr_mac.sv =====
module wsr_mac import wsr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  logic [MULK_W-1:0]          i_mulk,
    input  logic signed [SAMPLE_W-1:0] i_tap_data,
    output logic                       o_busy,
    output logic signed [ACC_W-1:0]    o_acc
);

    localparam logic [DIST_W:0] ZERO_LIMIT = (DIST_W + 1)'((HALF_TAPS - 1) * 65536);

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    logic [DIST_W-1:0]           r_u1;
    logic [DIST_W+MULK_W-1:0]    r_p1;
    logic signed [SAMPLE_W-1:0]  r_dat2, r_dat3, r_dat4, r_dat5;
    logic                        r_zero3, r_zero4;
    logic [15:0]                 r_fr3;
    logic signed [ROM_W-1:0]     r_a3, r_b3, r_a4;
    logic signed [35:0]          r_p2;
    logic signed [37:0]          r_p3;
    logic signed [37:0]          r_p4;
    logic signed [ACC_W-1:0]     r_acc;

    logic [DIST_W:0]             u2;
    logic                        zero2;
    logic [ROM_AW-1:0]           lo2;
    logic [ROM_AW-1:0]           hi2;
    logic [15:0]                 fr2;
    logic signed [ROM_W:0]       diff3;
    logic signed [19:0]          w4;
    logic signed [21:0]          w5;

    // Table address and fraction from the scaled distance
    always_comb begin
        u2    = r_p1[DIST_W+MULK_W-1:16];
        zero2 = (u2 >= ZERO_LIMIT);
        lo2   = zero2 ? '0 : {1'b0, u2[21:11]};
        hi2   = lo2 + 1'b1;
        fr2   = {u2[10:0], 5'b0};
    end

    assign diff3 = (ROM_W + 1)'(r_b3) - (ROM_W + 1)'(r_a3);
    assign w4    = r_zero4 ? '0 : 20'(r_a4) + 20'(r_p2 >>> 16);
    assign w5    = r_p3[37:16];

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.tap_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Datapath: scale, look up, interpolate, weight, multiply
    always_ff @(posedge i_clk) begin
        r_u1    <= i_ctl.tap_dist;
        r_p1    <= r_u1 * i_mulk;
        r_dat2  <= i_tap_data;
        r_zero3 <= zero2;
        r_fr3   <= fr2;
        r_a3    <= SINC_ROM[lo2];
        r_b3    <= SINC_ROM[hi2];
        r_dat3  <= r_dat2;
        r_p2    <= diff3 * signed'({1'b0, r_fr3});
        r_a4    <= r_a3;
        r_zero4 <= r_zero3;
        r_dat4  <= r_dat3;
        r_p3    <= w4 * signed'({1'b0, i_mulk});
        r_dat5  <= r_dat4;
        r_p4    <= 38'(r_dat5) * 38'(w5);
    end

    // Accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_v6) begin
            r_acc <= r_acc + ACC_W'(r_p4);
        end
    end

    assign o_busy = r_v1 | r_v2 | r_v3 | r_v4 | r_v5 | r_v6;
    assign o_acc  = r_acc;

endmodule

// ===== rtl/windowed_sinc_resampler.sv =====
// Windowed-sinc resampler. Samples come in blocks; the first item of a block
// (i_first_of_block) restarts time and sets the block length. Each accepted item
// yields zero to 64 output samples; every output is a sum of up to 127 taps of a
// 136-entry delay line, one tap per cycle into a seven-stage multiply-accumulate
// pipeline. Each output takes a setup step, the tap issue, a drain of the
// pipeline, a time step and an emit, and may also wait on a stalled output.
// After the last item of a block the final sample is written up to 136 more
// times, one per cycle. After reset the delay line is cleared before the first
// item is taken. Configuration must be written only while the block is idle;
// the block itself does not enforce this.
module windowed_sinc_resampler import wsr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_index,
    input  logic [RATIO_W-1:0]         i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_first_of_block,
    input  logic [15:0]                i_block_length,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_last_of_run,
    output logic                       o_block_done
);

    t_state r_state, n_state;

    logic [RATIO_W-1:0]         r_ratio;
    logic [MULK_W-1:0]          r_inv;
    logic [15:0]                r_len;
    logic [15:0]                r_inpos;
    logic [TIME_W-1:0]          r_t;
    logic [6:0]                 r_cnt;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [FT_W-1:0]            r_j;
    logic [FT_W-1:0]            r_jend;
    logic [LINE_AW-1:0]         r_npush;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;
    logic                       r_out_done;

    t_line_req                  line_req;
    t_mac_ctl                   mac_ctl;
    logic                       ram_ready;
    logic signed [SAMPLE_W-1:0] tap_data;
    logic                       mac_busy;
    logic signed [ACC_W-1:0]    mac_acc;

    logic [RATIO_W-1:0]         eff_ratio;
    logic [MULK_W-1:0]          eff_inv;
    logic [MULK_W-1:0]          mulk;
    logic [FT_W-1:0]            ft;
    logic                       more;
    logic [FT_W-1:0]            left;
    logic [FT_W:0]              right;
    logic                       in_acc;
    logic                       stray;
    logic                       out_free;
    logic                       fin_cond;
    logic [FT_W:0]              fin_n;
    logic [LINE_AW-1:0]         fin_n_clamp;
    logic signed [33:0]         dist_s;
    logic [33:0]                dist_abs;
    logic [FT_W:0]              idx_sum;
    logic signed [ACC_W-1:0]    round_sum;
    logic signed [ACC_W-17:0]   rounded;
    logic signed [SAMPLE_W-1:0] sat;

    // Clamp configuration and pick the argument scale
    always_comb begin
        if (r_ratio < RATIO_W'(1024)) begin
            eff_ratio = RATIO_W'(1024);
        end else if (r_ratio > RATIO_W'(4194304)) begin
            eff_ratio = RATIO_W'(4194304);
        end else begin
            eff_ratio = r_ratio;
        end
        if (r_inv < MULK_W'(1024)) begin
            eff_inv = MULK_W'(1024);
        end else if (r_inv > MULK_W'(65536)) begin
            eff_inv = MULK_W'(65536);
        end else begin
            eff_inv = r_inv;
        end
        mulk = (eff_ratio >= RATIO_W'(65536)) ? eff_inv : MULK_W'(65536);
    end

    // Output timing and tap range
    always_comb begin
        ft    = r_t[TIME_W-1:16];
        more  = !r_cnt[6] && (ft == {1'b0, r_inpos}) && (ft < {1'b0, r_len});
        left  = (ft >= FT_W'(HALF_TAPS - 1)) ? ft - FT_W'(HALF_TAPS - 1) : '0;
        right = {1'b0, ft} + (FT_W + 1)'(HALF_TAPS);
        if (right > (FT_W + 1)'(r_len)) begin
            right = (FT_W + 1)'(r_len);
        end
        fin_cond = ((17'(r_inpos) + 17'd1) == 17'(r_len)) &&
                   (({1'b0, ft} + 18'd1) >= 18'(r_len));
        fin_n = {1'b0, ft} + 18'd1 - 18'(r_len);
        fin_n_clamp = (fin_n > 18'(LINE_LEN)) ? LINE_AW'(LINE_LEN) : fin_n[LINE_AW-1:0];
    end

    // Tap distance and delay-line index
    always_comb begin
        dist_s   = signed'({1'b0, r_t}) - signed'({1'b0, r_j, 16'b0});
        dist_abs = dist_s[33] ? 34'(-dist_s) : 34'(dist_s);
        idx_sum  = {1'b0, r_j} + (FT_W + 1)'(HALF_TAPS) - {1'b0, ft};
    end

    // Round to nearest and saturate
    always_comb begin
        round_sum = mac_acc + ACC_W'(32768);
        rounded   = round_sum[ACC_W-1:16];
        if (rounded > (ACC_W - 16)'(32767)) begin
            sat = 16'sh7FFF;
        end else if (rounded < -(ACC_W - 16)'(32768)) begin
            sat = -16'sh8000;
        end else begin
            sat = rounded[SAMPLE_W-1:0];
        end
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign stray    = !i_first_of_block &&
                      ((r_len == '0) || ((17'(r_inpos) + 17'd1) >= 17'(r_len)));
    assign out_free = !r_out_valid || !i_stall;

    // Next state and datapath controls
    always_comb begin
        n_state          = r_state;
        line_req.push    = 1'b0;
        line_req.wdata   = i_sample_in;
        line_req.rd_idx  = idx_sum[IDX_W-1:0];
        mac_ctl.clr       = 1'b0;
        mac_ctl.tap_valid = 1'b0;
        mac_ctl.tap_dist  = dist_abs[DIST_W-1:0];
        case (r_state)
            ST_CLEAR: begin
                if (ram_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && !stray) begin
                    line_req.push = !i_first_of_block;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (more) begin
                    mac_ctl.clr = 1'b1;
                    n_state = ST_TAPS;
                end else begin
                    n_state = ST_FINAL;
                end
            end
            ST_TAPS: begin
                mac_ctl.tap_valid = 1'b1;
                if (r_j == r_jend) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_CHECK;
                end
            end
            ST_FINAL: begin
                if (fin_cond && (fin_n_clamp != '0)) begin
                    n_state = ST_PUSHN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PUSHN: begin
                line_req.push  = 1'b1;
                line_req.wdata = r_sample;
                if (r_npush == LINE_AW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_W'(65536);
            r_inv   <= MULK_W'(65536);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_RATIO:   r_ratio <= i_cfg_data;
                REG_INVERSE: r_inv   <= i_cfg_data[MULK_W-1:0];
                default:     r_ratio <= r_ratio;
            endcase
        end
    end

    // Block position and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_inpos <= '0;
            r_t     <= '0;
            r_cnt   <= '0;
            r_npush <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && !stray) begin
                        r_cnt <= '0;
                        if (i_first_of_block) begin
                            r_len   <= (i_block_length == '0) ? 16'd1 : i_block_length;
                            r_inpos <= '0;
                            r_t     <= '0;
                        end else begin
                            r_inpos <= r_inpos + 1'b1;
                        end
                    end
                end
                ST_STEP: begin
                    r_t   <= r_t + TIME_W'(eff_ratio);
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_FINAL: begin
                    r_npush <= fin_n_clamp;
                end
                ST_PUSHN: begin
                    r_npush <= r_npush - 1'b1;
                end
                default: begin
                    r_npush <= r_npush;
                end
            endcase
        end
    end

    // Held sample and tap counter
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample_in;
        end
        if (r_state == ST_CHECK) begin
            r_j    <= left;
            r_jend <= FT_W'(right - 1'b1);
        end else if (r_state == ST_TAPS) begin
            r_j <= r_j + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            r_out_sample <= sat;
            r_out_last   <= !more;
            r_out_done   <= (ft >= {1'b0, r_len});
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_last_of_run = r_out_last;
    assign o_block_done  = r_out_done;

    wsr_delay_ram u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (line_req),
        .o_ready   (ram_ready),
        .o_rd_data (tap_data)
    );

    wsr_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mac_ctl),
        .i_mulk     (mulk),
        .i_tap_data (tap_data),
        .o_busy     (mac_busy),
        .o_acc      (mac_acc)
    );

`ifndef NO_ASSERTIONS
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mac_busy)
        else $error("tap pipeline busy while idle");

    a_no_push_in_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_req.push |-> !mac_ctl.tap_valid)
        else $error("delay line written during tap issue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'(MAX_RESULTS))
        else $error("too many outputs for one transaction");
`endif

endmodule

// ===== tb/sv/windowed_sinc_resampler_tb.sv =====
module windowed_sinc_resampler_tb;
    import wsr_pkg::*;

    localparam int          SETTLE   = 400;
    localparam longint      ONE_Q16  = 65536;
    localparam longint      RATIO_LO = 1024;
    localparam longint      RATIO_HI = 4194304;

    typedef enum logic [1:0] {
        K_DATA,
        K_CFG,
        K_SYNC
    } t_item_kind;

    typedef struct {
        t_item_kind          kind;
        logic signed [15:0]  sample;
        logic                first;
        logic [15:0]         len;
        logic                idx;
        logic [RATIO_W-1:0]  val;
    } t_item;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
        logic               done;
    } t_out_sample;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic                       i_cfg_index = REG_RATIO;
    logic [RATIO_W-1:0]         i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       i_first_of_block = 1'b0;
    logic [15:0]                i_block_length = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_last_of_run;
    logic                       o_block_done;

    windowed_sinc_resampler DUT (.*);

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_item              pending_items[$];
    t_out_sample        expected_outputs[$];
    int                 mismatches = 0;
    bit                 calm = 1'b0;

    // Shadow of the converter state
    longint             sinc_tab[0:TAB_LEN];
    logic signed [15:0] taps_line[0:LINE_LEN-1];
    longint unsigned    time_q16, in_pos, blk_len, ratio_reg, inv_reg;

    // sin(pi*n/d) in Q30
    function automatic longint sin_q30(longint unsigned n, longint unsigned d);
        longint unsigned m, a, term;
        bit              neg;
        longint          sum;
        m = n % (2 * d);
        neg = (m >= d);
        if (neg) m = m - d;
        if (2 * m > d) m = d - m;
        a = (longint'(PI_Q30) * m) / d;
        term = a;
        sum = longint'(a);
        for (longint unsigned k = 1; k <= 9; k++) begin
            term = (((term * a) >> 30) * a) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        return neg ? -sum : sum;
    endfunction

    function automatic void build_sinc_table();
        longint          s, c;
        longint unsigned mag, den, sq, w, v;
        sinc_tab[0] = 65536;
        for (longint unsigned i = 1; i < TAB_LEN; i++) begin
            s = sin_q30(i, STEPS);
            mag = (s < 0) ? longint'(-s) : longint'(s);
            den = longint'(PI_Q30) * i;
            sq = (mag * STEPS * 65536 + den / 2) / den;
            c = sin_q30(2 * i + TAB_LEN, 2 * TAB_LEN);
            w = longint'(64'sd1073741824 + c);
            v = (sq * w + 64'd1073741824) >> 31;
            sinc_tab[i] = (s < 0) ? -longint'(v) : longint'(v);
        end
        sinc_tab[TAB_LEN] = 0;
    endfunction

    function automatic longint unsigned eff_ratio();
        if (ratio_reg < RATIO_LO) return RATIO_LO;
        if (ratio_reg > RATIO_HI) return RATIO_HI;
        return ratio_reg;
    endfunction

    function automatic longint unsigned eff_inverse();
        if (inv_reg < RATIO_LO) return RATIO_LO;
        if (inv_reg > ONE_Q16) return ONE_Q16;
        return inv_reg;
    endfunction

    // Interpolated windowed sinc at Q16 distance u
    function automatic longint sinc_at(longint unsigned u);
        longint unsigned tmp, lo;
        longint          fr, a, b;
        if (u >= (longint'(HALF_TAPS - 1) << 16)) return 0;
        tmp = u * STEPS;
        lo = tmp >> 16;
        fr = longint'(tmp & 64'hFFFF);
        if (lo + 1 >= TAB_LEN) return 0;
        a = sinc_tab[lo];
        b = sinc_tab[lo + 1];
        return a + (((b - a) * fr) >>> 16);
    endfunction

    function automatic void shift_in(logic signed [15:0] s);
        for (int i = 0; i < LINE_LEN - 1; i++) taps_line[i] = taps_line[i + 1];
        taps_line[LINE_LEN - 1] = s;
    endfunction

    function automatic logic signed [15:0] tap_sum(longint unsigned t);
        longint unsigned ft, left, right, idx, u;
        longint          acc, d, w, data, inv, r;
        bit              scaled;
        ft = t >> 16;
        left = (ft >= HALF_TAPS - 1) ? ft - (HALF_TAPS - 1) : 0;
        right = ft + HALF_TAPS;
        if (right > blk_len) right = blk_len;
        scaled = (eff_ratio() >= ONE_Q16);
        inv = longint'(eff_inverse());
        acc = 0;
        for (longint unsigned j = left; j < right; j++) begin
            idx = j + HALF_TAPS - ft;
            data = (idx < LINE_LEN) ? longint'(taps_line[idx]) : 0;
            d = longint'(t) - longint'(j << 16);
            u = (d < 0) ? longint'(-d) : longint'(d);
            if (scaled) begin
                u = (u * longint'(inv)) >> 16;
                w = (sinc_at(u) * inv) >>> 16;
            end else begin
                w = sinc_at(u);
            end
            acc = acc + data * w;
        end
        r = (acc + 32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    // Advance the shadow state by one accepted transaction and queue its outputs
    function automatic void resample_item(t_item it);
        int              cnt;
        t_out_sample     o;
        longint unsigned n;
        cnt = 0;
        if (it.first) begin
            blk_len = (it.len == 0) ? 1 : it.len;
            in_pos = 0;
            time_q16 = 0;
        end else begin
            if (blk_len == 0 || in_pos + 1 >= blk_len) return;
            in_pos++;
            shift_in(it.sample);
        end
        while (cnt < MAX_RESULTS && (time_q16 >> 16) == in_pos && (time_q16 >> 16) < blk_len) begin
            o.sample = tap_sum(time_q16);
            time_q16 = time_q16 + eff_ratio();
            o.last = 1'b0;
            o.done = ((time_q16 >> 16) >= blk_len);
            expected_outputs.push_back(o);
            cnt++;
        end
        if (cnt > 0) expected_outputs[$].last = 1'b1;
        if (in_pos + 1 == blk_len && (time_q16 >> 16) + 1 >= blk_len) begin
            n = (time_q16 >> 16) + 1 - blk_len;
            if (n > LINE_LEN) n = LINE_LEN;
            for (longint unsigned i = 0; i < n; i++) shift_in(it.sample);
        end
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Driver: feed queued transactions, hold while stalled, settle before writes
    int  gap_cnt = 0;
    int  settle_cnt = SETTLE;
    t_item cur;
    always @(posedge i_clk) begin
        logic               nv, nwr, nfirst, nidx;
        logic signed [15:0] nsamp;
        logic [15:0]        nlen;
        logic [RATIO_W-1:0] ndata;
        t_item              head;
        nv = i_valid; nwr = 1'b0; nfirst = i_first_of_block; nsamp = i_sample_in;
        nlen = i_block_length; nidx = i_cfg_index; ndata = i_cfg_data;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                resample_item(cur);
                nv = 1'b0;
                if ($urandom_range(0, 39) == 0) calm = !calm;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pending_items.size() > 0) begin
                    head = pending_items[0];
                    if (head.kind == K_DATA) begin
                        void'(pending_items.pop_front());
                        cur = head;
                        nv = 1'b1;
                        nsamp = head.sample;
                        nfirst = head.first;
                        nlen = head.len;
                        gap_cnt = calm ? 0 : $urandom_range(0, 3);
                    end else if (expected_outputs.size() != 0) begin
                        settle_cnt = SETTLE;
                    end else if (settle_cnt > 0) begin
                        settle_cnt--;
                    end else begin
                        void'(pending_items.pop_front());
                        settle_cnt = SETTLE;
                        if (head.kind == K_CFG) begin
                            nwr = 1'b1;
                            nidx = head.idx;
                            ndata = head.val;
                            if (head.idx == REG_RATIO) ratio_reg = head.val;
                            else inv_reg = head.val & 23'h1FFFF;
                        end
                    end
                end
            end
        end
        i_valid <= nv;
        i_cfg_wr_en <= nwr;
        i_first_of_block <= nfirst;
        i_sample_in <= nsamp;
        i_block_length <= nlen;
        i_cfg_index <= nidx;
        i_cfg_data <= ndata;
    end

    // Monitor: check each output transaction, draw receiver stalls
    int stall_cnt = 0;
    always @(posedge i_clk) begin
        t_out_sample e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_outputs.size() == 0) begin
                flag_mismatch("unexpected output, sample", o_sample_out, 0);
            end else begin
                e = expected_outputs.pop_front();
                if (o_sample_out !== e.sample) flag_mismatch("sample_out", o_sample_out, e.sample);
                if (o_last_of_run !== e.last) flag_mismatch("last_of_run", o_last_of_run, e.last);
                if (o_block_done !== e.done) flag_mismatch("block_done", o_block_done, e.done);
            end
            stall_cnt = calm ? 0 : $urandom_range(0, 3);
        end
        if (stall_cnt > 0) begin
            stall_cnt--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic void add_data(logic signed [15:0] s, logic f, logic [15:0] l);
        t_item it;
        it.kind = K_DATA; it.sample = s; it.first = f; it.len = l; it.idx = REG_RATIO; it.val = '0;
        pending_items.push_back(it);
    endfunction

    function automatic void add_cfg(logic idx, logic [RATIO_W-1:0] v);
        t_item it;
        it.kind = K_CFG; it.sample = '0; it.first = 1'b0; it.len = '0; it.idx = idx; it.val = v;
        pending_items.push_back(it);
    endfunction

    function automatic logic signed [15:0] pick_sample(int mode);
        case ($urandom_range(0, 5))
            0: return (mode % 2) ? 16'sd32767 : -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd32768;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stimulus and end of run
    initial begin
        t_item           sync;
        longint unsigned r, v;
        int              n, cnt, len, k;
        build_sinc_table();
        for (int i = 0; i < LINE_LEN; i++) taps_line[i] = '0;
        time_q16 = 0; in_pos = 0; blk_len = 0; ratio_reg = ONE_Q16; inv_reg = ONE_Q16;

        // Directed: stray item, zero length, extremes, early restart
        add_data(16'sd100, 1'b0, 16'd5);
        add_data(16'sd32767, 1'b1, 16'd0);
        add_data(-16'sd1, 1'b0, 16'd0);
        add_data(-16'sd32768, 1'b1, 16'd4);
        add_data(16'sd32767, 1'b0, 16'd4);
        add_data(-16'sd32768, 1'b0, 16'd4);
        add_data(16'sd32767, 1'b0, 16'd4);
        add_data(16'sd1234, 1'b1, 16'hFFFF);
        add_data(16'sd0, 1'b0, 16'd0);
        add_data(-16'sd1, 1'b0, 16'd0);
        add_data(16'sd500, 1'b1, 16'd3);
        add_data(-16'sd500, 1'b0, 16'd3);
        // Ratio and inverse above range: outputs only at block start
        add_cfg(REG_RATIO, 23'h7FFFFF);
        add_cfg(REG_INVERSE, 23'h1FFFF);
        for (int i = 0; i < 5; i++) add_data(pick_sample(i), i == 0, 16'd5);
        // Ratio and inverse below range: a full run of outputs per transaction
        add_cfg(REG_RATIO, '0);
        add_cfg(REG_INVERSE, '0);
        add_data(16'sd32767, 1'b1, 16'd2);
        add_data(-16'sd32768, 1'b0, 16'd2);

        // Random phases
        for (int p = 0; p < 10; p++) begin
            case ((p == 1 || p == 6) ? 0 : $urandom_range(0, 5))
                0: r = $urandom_range(1024, 16383);
                1: r = $urandom_range(16384, 65535);
                2: r = $urandom_range(65536, 262144);
                3: r = $urandom_range(262145, 4194304);
                4: r = $urandom_range(0, 23'h7FFFFF);
                default: r = ONE_Q16;
            endcase
            case ($urandom_range(0, 2))
                0: v = $urandom_range(0, 23'h7FFFFF);
                1: v = (r < RATIO_LO) ? ONE_Q16 : (ONE_Q16 * ONE_Q16) / r;
                default: v = ONE_Q16;
            endcase
            if ($urandom_range(0, 1)) begin
                add_cfg(REG_RATIO, RATIO_W'(r)); add_cfg(REG_INVERSE, RATIO_W'(v));
            end else begin
                add_cfg(REG_INVERSE, RATIO_W'(v)); add_cfg(REG_RATIO, RATIO_W'(r));
            end
            if (p == 4) begin
                // Hold off until every queued output has come back
                sync.kind = K_SYNC; sync.sample = '0; sync.first = 1'b0;
                sync.len = '0; sync.idx = REG_RATIO; sync.val = '0;
                pending_items.push_back(sync);
            end
            n = (r < 16384) ? 12 : 52;
            cnt = 0;
            while (cnt < n) begin
                if (r < 16384) len = $urandom_range(1, 3);
                else if ($urandom_range(0, 19) == 0) len = 0;
                else if ($urandom_range(0, 9) == 0) len = $urandom_range(41, 65535);
                else len = $urandom_range(1, 40);
                k = (len == 0) ? 1 : len;
                if ($urandom_range(0, 7) == 0) k = $urandom_range(1, k);
                if (k > n - cnt) k = n - cnt;
                if (k < 1) k = 1;
                for (int i = 0; i < k; i++) add_data(pick_sample(i), i == 0, 16'(len));
                cnt += k;
                if ($urandom_range(0, 7) == 0) begin
                    add_data(16'($urandom), 1'b0, 16'($urandom));
                    cnt++;
                end
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_outputs.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_outputs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit
    initial begin
        #400000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wsr_pkg.sv
rtl/wsr_delay_ram.sv
rtl/wsr_mac.sv
rtl/windowed_sinc_resampler.sv
tb/sv/windowed_sinc_resampler_tb.sv
